// ===== hdl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Payload structs, pipeline stage records and datapath widths.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int SREM_W     = ROOT_W + 3;
  localparam int DIVD_W     = 32;
  localparam int DIVS_W     = 16;
  localparam int DREM_W     = DIVS_W + 1;

  typedef struct packed {
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic signed [31:0] first_real;
    logic signed [31:0] first_imag;
    logic signed [31:0] second_real;
    logic signed [31:0] second_imag;
    logic               roots_complex;
    logic               degenerate;
    logic               saturated;
  } qrs_out_t;

  // per-item data that rides along the cells
  typedef struct packed {
    logic              a_neg;
    logic [DIVS_W-1:0] a_mag;
    logic              num_neg;
    logic [15:0]       b_mag;
    logic              cplx;
    logic              degen;
  } qrs_side_t;

  typedef struct packed {
    logic              valid;
    qrs_side_t         side;
    logic [RAD_W-1:0]  rad;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } qrs_sqrt_t;

  typedef struct packed {
    logic              valid;
    qrs_side_t         side;
    logic [DIVD_W-1:0] n1;
    logic [DREM_W-1:0] r1;
    logic [DIVD_W-1:0] q1;
    logic [DIVD_W-1:0] n2;
    logic [DREM_W-1:0] r2;
    logic [DIVD_W-1:0] q2;
  } qrs_div_t;

endpackage

// ===== hdl/qrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit of the square root chain
// Restoring square root step: brings down two radicand bits, sets one root bit.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  qrs_sqrt_t d,
  output qrs_sqrt_t q
);

  logic [SREM_W-1:0] rem_sh;
  logic [SREM_W-1:0] trial;
  logic              ge;
  qrs_sqrt_t         q_next;

  always_comb begin
    rem_sh = {d.rem[SREM_W-3:0], d.rad[RAD_W-1 -: 2]};
    trial  = SREM_W'({d.root, 2'b01});
    ge     = rem_sh >= trial;
    q_next       = d;
    q_next.rad   = {d.rad[RAD_W-3:0], 2'b00};
    q_next.rem   = ge ? rem_sh - trial : rem_sh;
    q_next.root  = {d.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= q_next;
    end
  end

endmodule

// ===== hdl/qrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_div_cell: one quotient bit of the two dividers
// Restoring division step for both -b/2a and sqrt/2a, sharing the divisor.
// ----------------------------------------------------------------------------
module qrs_div_cell
  import qrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  qrs_div_t d,
  output qrs_div_t q
);

  logic [DREM_W-1:0] dvs;
  logic [DREM_W-1:0] t1;
  logic [DREM_W-1:0] t2;
  logic              ge1;
  logic              ge2;
  qrs_div_t          q_next;

  always_comb begin
    dvs = DREM_W'(d.side.a_mag);
    t1  = {d.r1[DREM_W-2:0], d.n1[DIVD_W-1]};
    t2  = {d.r2[DREM_W-2:0], d.n2[DIVD_W-1]};
    ge1 = t1 >= dvs;
    ge2 = t2 >= dvs;
    q_next    = d;
    q_next.n1 = {d.n1[DIVD_W-2:0], 1'b0};
    q_next.n2 = {d.n2[DIVD_W-2:0], 1'b0};
    q_next.r1 = ge1 ? t1 - dvs : t1;
    q_next.r2 = ge2 ? t2 - dvs : t2;
    q_next.q1 = {d.q1[DIVD_W-2:0], ge1};
    q_next.q2 = {d.q2[DIVD_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q <= q_next;
    end
  end

endmodule

// ===== hdl/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver: both roots of a*x^2 + b*x + c in fixed point
// Q8.8 coefficients in, Q16.16 saturated roots out, one set per cycle unless stalled.
// ----------------------------------------------------------------------------
// Channels: coef (valid/ready) carries a, b, c; roots (valid/ready) carries
// both roots with the complex, degenerate and saturated flags.
// One transfer is taken every cycle while the result side keeps up.
// From coef transfer to roots valid an item passes the product and
// discriminant registers, 32 square root cells (one root bit each),
// 32 divider cells (one quotient bit each) and the output register.
// The whole chain advances together; when the receiver stalls, coef_ready
// drops in the same cycle and everything in flight holds its place, so no
// result is lost while the output register waits.
// A zero coefficient a gives zero roots with degenerate set.
// Reset clears all valid flags; nothing else needs clearing.
// ----------------------------------------------------------------------------
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     coef_valid,
  output logic     coef_ready,
  input  qrs_in_t  coef,
  output logic     roots_valid,
  input  logic     roots_ready,
  output qrs_out_t roots
);

  logic adv;

  // product stage
  logic               f1_valid;
  logic signed [31:0] f1_bb;
  logic signed [31:0] f1_ac;
  qrs_side_t          f1_side;
  qrs_side_t          side_in;

  logic signed [34:0] disc;
  logic [34:0]        disc_mag;
  qrs_side_t          sq0_side;

  qrs_sqrt_t sq [0:SQRT_STEPS];
  qrs_div_t  dv [0:DIV_STEPS];

  assign adv        = !roots_valid || roots_ready;
  assign coef_ready = adv;

  always_comb begin
    side_in.a_neg   = coef.coef_a[15];
    side_in.a_mag   = coef.coef_a[15] ? 16'(-coef.coef_a) : 16'(coef.coef_a);
    side_in.num_neg = !coef.coef_b[15] && (coef.coef_b != 16'sd0);
    side_in.b_mag   = coef.coef_b[15] ? 16'(-coef.coef_b) : 16'(coef.coef_b);
    side_in.cplx    = 1'b0;
    side_in.degen   = coef.coef_a == 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= coef_valid;
      f1_bb    <= coef.coef_b * coef.coef_b;
      f1_ac    <= coef.coef_a * coef.coef_c;
      f1_side  <= side_in;
    end
  end

  // discriminant stage
  always_comb begin
    disc          = 35'(f1_bb) - (35'(f1_ac) <<< 2);
    disc_mag      = disc[34] ? 35'(-disc) : 35'(disc);
    sq0_side      = f1_side;
    sq0_side.cplx = disc[34];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else if (adv) begin
      sq[0].valid     <= f1_valid;
      sq[0].side      <= sq0_side;
      sq[0].rad       <= {1'b0, disc_mag[32:0], 30'd0};
      sq[0].rem       <= '0;
      sq[0].root      <= '0;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .d   (sq[i]),
      .q   (sq[i+1])
    );
  end

  always_comb begin
    dv[0].valid = sq[SQRT_STEPS].valid;
    dv[0].side  = sq[SQRT_STEPS].side;
    dv[0].n1    = {1'b0, sq[SQRT_STEPS].side.b_mag, 15'd0};
    dv[0].r1    = '0;
    dv[0].q1    = '0;
    dv[0].n2    = sq[SQRT_STEPS].root;
    dv[0].r2    = '0;
    dv[0].q2    = '0;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    qrs_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .d   (dv[i]),
      .q   (dv[i+1])
    );
  end

  // sign, combine and clip
  function automatic logic [32:0] clip(input logic signed [34:0] v);
    logic [32:0] r;
    if (v > 35'sd2147483647) begin
      r = {1'b1, 32'h7fffffff};
    end else if (v < -35'sd2147483648) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  qrs_div_t           fin;
  logic signed [34:0] c1;
  logic signed [34:0] c2;
  logic [32:0]        p0;
  logic [32:0]        p1;
  logic [32:0]        p2;
  logic [32:0]        p3;
  qrs_out_t           roots_next;

  always_comb begin
    fin = dv[DIV_STEPS];
    c1  = 35'({3'b000, fin.q1});
    c2  = 35'({3'b000, fin.q2});
    if (fin.side.num_neg ^ fin.side.a_neg) c1 = -c1;
    if (fin.side.a_neg) c2 = -c2;
    if (fin.side.cplx) begin
      p0 = clip(c1);
      p1 = clip(c2);
      p2 = clip(c1);
      p3 = clip(-c2);
    end else begin
      p0 = clip(c1 + c2);
      p1 = '0;
      p2 = clip(c1 - c2);
      p3 = '0;
    end
    if (fin.side.degen) begin
      roots_next = '0;
      roots_next.degenerate = 1'b1;
    end else begin
      roots_next.first_real    = p0[31:0];
      roots_next.first_imag    = p1[31:0];
      roots_next.second_real   = p2[31:0];
      roots_next.second_imag   = p3[31:0];
      roots_next.roots_complex = fin.side.cplx;
      roots_next.degenerate    = 1'b0;
      roots_next.saturated     = p0[32] | p1[32] | p2[32] | p3[32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roots_valid <= 1'b0;
    end else if (adv) begin
      roots_valid <= fin.valid;
      roots       <= roots_next;
    end
  end

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    roots_valid && roots.degenerate |->
      roots.first_real == 32'sd0 && roots.second_real == 32'sd0 &&
      !roots.roots_complex && !roots.saturated)
    else $error("degenerate result with nonzero roots");

  a_real_no_imag : assert property (@(posedge clk) disable iff (rst)
    roots_valid && !roots.roots_complex |->
      roots.first_imag == 32'sd0 && roots.second_imag == 32'sd0)
    else $error("real roots with imaginary part");

  a_conj_real : assert property (@(posedge clk) disable iff (rst)
    roots_valid && roots.roots_complex |-> roots.first_real == roots.second_real)
    else $error("complex roots not conjugate");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    roots_valid && !roots_ready |-> !coef_ready)
    else $error("coef accepted while result stalled");

endmodule
